// ===== rtl/core/bfp_pkg.sv =====
// Shared constants, codes and control types for the block flash target.
package bfp_pkg;

  // Default array geometry
  localparam int BANK_COUNT_DEF       = 1;
  localparam int BLOCKS_EACH_BANK_DEF = 64;
  localparam int BYTES_PER_BLOCK_DEF  = 64;

  // Fixed field widths
  localparam int CMD_W      = 4;
  localparam int VAL_W      = 8;
  localparam int IDX_W      = 6;
  localparam int DATA_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INIT       = 4'd0;
  localparam logic [CMD_W-1:0] CMD_BANK       = 4'd1;
  localparam logic [CMD_W-1:0] CMD_BLOCK      = 4'd2;
  localparam logic [CMD_W-1:0] CMD_CHECKSUM   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_VERIFY     = 4'd4;
  localparam logic [CMD_W-1:0] CMD_PROGRAM    = 4'd5;
  localparam logic [CMD_W-1:0] CMD_ERASE      = 4'd6;
  localparam logic [CMD_W-1:0] CMD_ID         = 4'd7;
  localparam logic [CMD_W-1:0] CMD_REVISION   = 4'd8;
  localparam logic [CMD_W-1:0] CMD_SECURE     = 4'd9;
  localparam logic [CMD_W-1:0] CMD_READSECURE = 4'd10;
  localparam logic [CMD_W-1:0] CMD_WRBYTE     = 4'd11;
  localparam logic [CMD_W-1:0] CMD_RDBYTE     = 4'd12;
  localparam logic [CMD_W-1:0] CMD_STATUS     = 4'd13;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0]  REG_DEVICE_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_DEVICE_REV = 2'd1;
  localparam logic [CFG_DATA_W-1:0] DEVICE_ID_RST  = 16'h0019;
  localparam logic [CFG_DATA_W-1:0] DEVICE_REV_RST = 16'h0000;

  // Sweep modes of the datapath copy engine
  typedef enum logic [2:0] {
    MODE_CLEAR,
    MODE_ERASE,
    MODE_VERIFY,
    MODE_PROGRAM,
    MODE_SECURE,
    MODE_RDSEC,
    MODE_SUM
  } bfp_mode_e;

  // Controller to datapath
  typedef struct packed {
    logic               capture;
    logic [CMD_W-1:0]   cmd;
    logic               sweep_start;
    bfp_mode_e          mode;
    logic               prot_rd;
    logic               buf_rd;
    logic               finish;
    logic               denied;
  } bfp_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_done;
    logic refuse_verify;
    logic refuse_program;
  } bfp_stat_t;

endpackage

// ===== rtl/core/bfp_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
module bfp_ram #(
  parameter int   WIDTH = 8,
  parameter int   DEPTH = 64,
  localparam int  AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bfp_ctrl.sv =====
// Command sequencer: accepts items, steps through protection check and sweeps.
module bfp_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [bfp_pkg::CMD_W-1:0] command_i,
  input  bfp_pkg::bfp_stat_t       stat_i,
  output bfp_pkg::bfp_ctl_t        ctl_o
);
  import bfp_pkg::*;

  localparam logic [2:0] S_RST    = 3'd0;
  localparam logic [2:0] S_CLRW   = 3'd1;
  localparam logic [2:0] S_IDLE   = 3'd2;
  localparam logic [2:0] S_DECODE = 3'd3;
  localparam logic [2:0] S_PCHK   = 3'd4;
  localparam logic [2:0] S_RDB    = 3'd5;
  localparam logic [2:0] S_SWEEP  = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CMD_W-1:0] cmd_q, cmd_d;
  logic             refused;

  // Next state and commands to the datapath
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    ctl_o   = '0;
    ctl_o.cmd  = cmd_q;
    ctl_o.mode = MODE_CLEAR;
    refused = (cmd_q == CMD_VERIFY) ? stat_i.refuse_verify : stat_i.refuse_program;
    unique case (state_q)
      S_RST: begin
        ctl_o.sweep_start = 1'b1;
        ctl_o.mode        = MODE_CLEAR;
        state_d           = S_CLRW;
      end
      S_CLRW: begin
        if (stat_i.sweep_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_d         = command_i;
          ctl_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (cmd_q) inside
          CMD_VERIFY, CMD_PROGRAM: begin
            ctl_o.prot_rd = 1'b1;
            state_d       = S_PCHK;
          end
          CMD_RDBYTE: begin
            ctl_o.buf_rd = 1'b1;
            state_d      = S_RDB;
          end
          CMD_CHECKSUM: begin
            ctl_o.sweep_start = 1'b1;
            ctl_o.mode        = MODE_SUM;
            state_d           = S_SWEEP;
          end
          CMD_ERASE: begin
            ctl_o.sweep_start = 1'b1;
            ctl_o.mode        = MODE_ERASE;
            state_d           = S_SWEEP;
          end
          CMD_SECURE: begin
            ctl_o.sweep_start = 1'b1;
            ctl_o.mode        = MODE_SECURE;
            state_d           = S_SWEEP;
          end
          CMD_READSECURE: begin
            ctl_o.sweep_start = 1'b1;
            ctl_o.mode        = MODE_RDSEC;
            state_d           = S_SWEEP;
          end
          default: begin
            ctl_o.finish = 1'b1;
            state_d      = S_IDLE;
          end
        endcase
      end
      S_PCHK: begin
        if (refused) begin
          ctl_o.finish = 1'b1;
          ctl_o.denied = 1'b1;
          state_d      = S_IDLE;
        end else begin
          ctl_o.sweep_start = 1'b1;
          ctl_o.mode        = (cmd_q == CMD_VERIFY) ? MODE_VERIFY : MODE_PROGRAM;
          state_d           = S_SWEEP;
        end
      end
      S_RDB: begin
        ctl_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      S_SWEEP: begin
        if (stat_i.sweep_done) state_d = S_FIN;
      end
      S_FIN: begin
        ctl_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and latched command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RST;
      cmd_q   <= CMD_INIT;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== rtl/core/bfp_dp.sv =====
// Datapath: flash, protection and buffer RAMs, sweep engine, selects and result.
module bfp_dp #(
  parameter int BANK_COUNT       = bfp_pkg::BANK_COUNT_DEF,
  parameter int BLOCKS_EACH_BANK = bfp_pkg::BLOCKS_EACH_BANK_DEF,
  parameter int BYTES_PER_BLOCK  = bfp_pkg::BYTES_PER_BLOCK_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bfp_pkg::bfp_ctl_t             ctl_i,
  output bfp_pkg::bfp_stat_t            stat_o,
  input  logic [bfp_pkg::VAL_W-1:0]     value_i,
  input  logic [bfp_pkg::IDX_W-1:0]     byte_index_i,
  input  logic                          cfg_we_i,
  input  logic [bfp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bfp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                          done_o,
  output logic [bfp_pkg::DATA_W-1:0]    read_data_o,
  output logic                          denied_o
);
  import bfp_pkg::*;

  localparam int BANK_BYTES  = BLOCKS_EACH_BANK * BYTES_PER_BLOCK;
  localparam int FLASH_DEPTH = BANK_COUNT * BANK_BYTES;
  localparam int PROT_DEPTH  = BANK_COUNT * BYTES_PER_BLOCK;
  localparam int FA_W        = $clog2(FLASH_DEPTH);
  localparam int PA_W        = $clog2(PROT_DEPTH);
  localparam int BY_W        = $clog2(BYTES_PER_BLOCK);
  localparam int BL_W        = $clog2(BLOCKS_EACH_BANK);
  localparam int BK_W        = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
  localparam int CNT_W       = $clog2(FLASH_DEPTH + 1);
  localparam logic [CNT_W-1:0] LEN_ARRAY = CNT_W'(FLASH_DEPTH);
  localparam logic [CNT_W-1:0] LEN_BLOCK = CNT_W'(BYTES_PER_BLOCK);
  localparam logic [CNT_W-1:0] LEN_PROT  = CNT_W'(PROT_DEPTH);
  localparam logic [VAL_W-1:0] BANK_MASK  = VAL_W'(BANK_COUNT - 1);
  localparam logic [VAL_W-1:0] BLOCK_MASK = VAL_W'(BLOCKS_EACH_BANK - 1);

  // Captured item and selection state
  logic [VAL_W-1:0]      value_q;
  logic [IDX_W-1:0]      idx_q;
  logic [BK_W-1:0]       bank_q;
  logic [BL_W-1:0]       block_q;
  logic                  status_q;
  logic [CFG_DATA_W-1:0] dev_id_q, dev_rev_q;

  // Sweep engine
  logic                  active_q, rvalid_q, prot_ok_q;
  logic [CNT_W-1:0]      cnt_q, waddr_q, len;
  bfp_mode_e             mode_q;
  logic [DATA_W-1:0]     sum_q;
  logic                  sweep_done, wide_mode;

  // Result
  logic                  done_q, denied_q;
  logic [DATA_W-1:0]     read_data_q, result_d;

  // Addressing
  logic                  idx_ok, prot_sel_ok, wr_byte;
  logic [BY_W-1:0]       buf_idx, cnt_off, waddr_off;
  logic [BL_W-1:0]       prot_sel;
  logic [PA_W-1:0]       prot_base, prot_chk_addr;
  logic [FA_W-1:0]       flash_base;
  logic [1:0]            prot_code;

  // RAM ports
  logic                  flash_we, prot_we, buf_we;
  logic [FA_W-1:0]       flash_waddr, flash_raddr;
  logic [PA_W-1:0]       prot_waddr, prot_raddr;
  logic [BY_W-1:0]       buf_waddr, buf_raddr;
  logic [VAL_W-1:0]      flash_wdata, flash_rdata, prot_wdata, prot_rdata;
  logic [VAL_W-1:0]      buf_wdata, buf_rdata;

  // Address arithmetic
  assign idx_ok        = 32'(idx_q) < BYTES_PER_BLOCK;
  assign buf_idx       = BY_W'(idx_q);
  assign cnt_off       = cnt_q[BY_W-1:0];
  assign waddr_off     = waddr_q[BY_W-1:0];
  assign prot_sel      = block_q >> 2;
  assign prot_sel_ok   = 32'(prot_sel) < BYTES_PER_BLOCK;
  assign prot_base     = PA_W'(bank_q) * PA_W'(BYTES_PER_BLOCK);
  assign prot_chk_addr = prot_base + PA_W'(prot_sel);
  assign flash_base    = FA_W'(bank_q) * FA_W'(BANK_BYTES)
                       + FA_W'(block_q) * FA_W'(BYTES_PER_BLOCK);

  // Protection code of the selected block
  assign prot_code = prot_ok_q ? prot_rdata[{block_q[1:0], 1'b0} +: 2] : 2'b00;
  assign stat_o.refuse_verify  = (prot_code != 2'b00);
  assign stat_o.refuse_program = prot_code[1];

  // Sweep length and completion
  assign wide_mode  = (mode_q == MODE_CLEAR) || (mode_q == MODE_ERASE) ||
                      (mode_q == MODE_SUM);
  assign len        = wide_mode ? LEN_ARRAY : LEN_BLOCK;
  assign sweep_done = active_q && (cnt_q == len);
  assign stat_o.sweep_done = sweep_done;

  assign wr_byte = ctl_i.finish && (ctl_i.cmd == CMD_WRBYTE) && idx_ok;

  // RAM port steering by sweep mode
  always_comb begin
    flash_we    = 1'b0;
    flash_waddr = waddr_q[FA_W-1:0];
    flash_wdata = '0;
    flash_raddr = flash_base + FA_W'(cnt_off);
    prot_we     = 1'b0;
    prot_waddr  = waddr_q[PA_W-1:0];
    prot_wdata  = '0;
    buf_we      = 1'b0;
    buf_waddr   = waddr_off;
    buf_wdata   = '0;
    case (mode_q)
      MODE_CLEAR: begin
        flash_we = rvalid_q;
        prot_we  = rvalid_q && (waddr_q < LEN_PROT);
        buf_we   = rvalid_q && (waddr_q < LEN_BLOCK);
      end
      MODE_ERASE: begin
        flash_we = rvalid_q;
        prot_we  = rvalid_q && (waddr_q < LEN_PROT);
      end
      MODE_VERIFY: begin
        buf_we    = rvalid_q;
        buf_wdata = flash_rdata;
      end
      MODE_PROGRAM: begin
        flash_we    = rvalid_q;
        flash_waddr = flash_base + FA_W'(waddr_off);
        flash_wdata = buf_rdata;
      end
      MODE_SECURE: begin
        prot_we    = rvalid_q;
        prot_waddr = prot_base + PA_W'(waddr_off);
        prot_wdata = buf_rdata;
      end
      MODE_RDSEC: begin
        buf_we    = rvalid_q;
        buf_wdata = prot_rdata;
      end
      MODE_SUM: begin
        flash_raddr = cnt_q[FA_W-1:0];
      end
      default: begin
        flash_we = 1'b0;
      end
    endcase
    // single buffer byte write from the command
    if (wr_byte) begin
      buf_we    = 1'b1;
      buf_waddr = buf_idx;
      buf_wdata = value_q;
    end
  end

  assign prot_raddr = ctl_i.prot_rd ? prot_chk_addr : prot_base + PA_W'(cnt_off);
  assign buf_raddr  = ctl_i.buf_rd ? buf_idx : cnt_off;

  bfp_ram #(.WIDTH(VAL_W), .DEPTH(FLASH_DEPTH)) u_flash (
    .clk_i   (clk_i),
    .we_i    (flash_we),
    .waddr_i (flash_waddr),
    .wdata_i (flash_wdata),
    .raddr_i (flash_raddr),
    .rdata_o (flash_rdata)
  );

  bfp_ram #(.WIDTH(VAL_W), .DEPTH(PROT_DEPTH)) u_prot (
    .clk_i   (clk_i),
    .we_i    (prot_we),
    .waddr_i (prot_waddr),
    .wdata_i (prot_wdata),
    .raddr_i (prot_raddr),
    .rdata_o (prot_rdata)
  );

  bfp_ram #(.WIDTH(VAL_W), .DEPTH(BYTES_PER_BLOCK)) u_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  // Sweep counter; each byte is written in the cycle after it is read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      rvalid_q <= 1'b0;
      cnt_q    <= '0;
      mode_q   <= MODE_CLEAR;
    end else begin
      rvalid_q <= active_q && (cnt_q != len);
      if (ctl_i.sweep_start) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
        mode_q   <= ctl_i.mode;
      end else if (active_q) begin
        if (sweep_done) active_q <= 1'b0;
        else            cnt_q    <= cnt_q + 1'b1;
      end
    end
  end

  // Write address, checksum and protection-read qualifier
  always_ff @(posedge clk_i) begin
    waddr_q   <= cnt_q;
    prot_ok_q <= prot_sel_ok;
    if (ctl_i.sweep_start) begin
      sum_q <= '0;
    end else if (rvalid_q && (mode_q == MODE_SUM)) begin
      sum_q <= sum_q + DATA_W'(flash_rdata);
    end
    if (ctl_i.capture) begin
      value_q <= value_i;
      idx_q   <= byte_index_i;
    end
  end

  // Selects, status flag and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q    <= '0;
      block_q   <= '0;
      status_q  <= 1'b0;
      dev_id_q  <= DEVICE_ID_RST;
      dev_rev_q <= DEVICE_REV_RST;
    end else begin
      if (cfg_we_i && (cfg_index_i == REG_DEVICE_ID))  dev_id_q  <= cfg_data_i;
      if (cfg_we_i && (cfg_index_i == REG_DEVICE_REV)) dev_rev_q <= cfg_data_i;
      if (ctl_i.finish) begin
        case (ctl_i.cmd) inside
          CMD_INIT, CMD_CHECKSUM, CMD_ERASE, CMD_ID, CMD_REVISION,
          CMD_SECURE, CMD_READSECURE: status_q <= 1'b0;
          CMD_VERIFY, CMD_PROGRAM:    status_q <= ctl_i.denied;
          CMD_BANK:                   bank_q   <= BK_W'(value_q & BANK_MASK);
          CMD_BLOCK:                  block_q  <= BL_W'(value_q & BLOCK_MASK);
          default:                    status_q <= status_q;
        endcase
      end
    end
  end

  // Result value
  always_comb begin
    case (ctl_i.cmd)
      CMD_CHECKSUM: result_d = sum_q;
      CMD_ID:       result_d = dev_id_q;
      CMD_REVISION: result_d = dev_rev_q;
      CMD_RDBYTE:   result_d = idx_ok ? DATA_W'(buf_rdata) : '0;
      CMD_STATUS:   result_d = DATA_W'(status_q);
      default:      result_d = '0;
    endcase
  end

  // Result register and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.finish) begin
      read_data_q <= result_d;
      denied_q    <= ctl_i.denied;
    end
  end

  assign done_o      = done_q;
  assign read_data_o = read_data_q;
  assign denied_o    = denied_q;

endmodule

// ===== rtl/core/block_flash_with_protection.sv =====
// Simple commands finish directly; rdbyte first reads the buffer, verify/program first read the
// protection code and, unless refused, sweep one block; secure/readsecure sweep one block and
// checksum/erase sweep the whole array (byte-wide RAM ports).
// One item at a time: busy drops as done_o rises; a new item is taken only while busy is low.
// Results cannot be held off. Reset clears selects and status at once, then a clearing
// pass over the whole array zeroes all RAMs, busy high.
module block_flash_with_protection #(
  parameter int BANK_COUNT       = bfp_pkg::BANK_COUNT_DEF,
  parameter int BLOCKS_EACH_BANK = bfp_pkg::BLOCKS_EACH_BANK_DEF,
  parameter int BYTES_PER_BLOCK  = bfp_pkg::BYTES_PER_BLOCK_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [bfp_pkg::CMD_W-1:0]      command_i,
  input  logic [bfp_pkg::VAL_W-1:0]      value_i,
  input  logic [bfp_pkg::IDX_W-1:0]      byte_index_i,
  output logic                           done_o,
  output logic [bfp_pkg::DATA_W-1:0]     read_data_o,
  output logic                           denied_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bfp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bfp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bfp_pkg::*;

  bfp_ctl_t  ctl;
  bfp_stat_t stat;
  logic      cfg_we;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  bfp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .command_i (command_i),
    .stat_i    (stat),
    .ctl_o     (ctl)
  );

  bfp_dp #(
    .BANK_COUNT       (BANK_COUNT),
    .BLOCKS_EACH_BANK (BLOCKS_EACH_BANK),
    .BYTES_PER_BLOCK  (BYTES_PER_BLOCK)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .value_i      (value_i),
    .byte_index_i (byte_index_i),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .read_data_o  (read_data_o),
    .denied_o     (denied_o)
  );

endmodule
